@@ sv/length_prefixed_body_parser_assert.svh @@
// Assertion shorthands shared by the parser modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef LENGTH_PREFIXED_BODY_PARSER_ASSERT_SVH
`define LENGTH_PREFIXED_BODY_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPBP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpbp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpbp assertion failed");

// The expression must never be true.
`define LPBP_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lpbp assertion failed");

`endif

@@ sv/lpbp_pkg.sv @@
package lpbp_pkg;

    // Words buffered between the intake and the parser.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] RES_IN_PROGRESS  = 3'd0;
    localparam logic [2:0] RES_ACCEPTED     = 3'd1;
    localparam logic [2:0] RES_TRUNC_INT    = 3'd2;
    localparam logic [2:0] RES_TRUNC_STRING = 3'd3;
    localparam logic [2:0] RES_TRAILING     = 3'd4;

    typedef struct packed {
        logic [7:0]  body_byte;
        logic        body_last;
        logic [63:0] message_id;
    } body_item_t;

    typedef struct packed {
        logic [1:0]         field_index;
        logic               data_valid;
        logic [7:0]         data_byte;
        logic               field_end;
        logic               length_valid;
        logic [31:0]        field_length;
        logic               status_valid;
        logic signed [31:0] status_word;
        logic [2:0]         body_result;
        logic [63:0]        message_id_out;
    } result_t;

    // Handshake from the intake queue toward the parser.
    typedef struct packed {
        logic       valid;
        body_item_t item;
    } queue_head_t;

endpackage

@@ sv/lpbp_front.sv @@
`include "length_prefixed_body_parser_assert.svh"

module lpbp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                body_valid,
    output logic                body_stall,
    input  lpbp_pkg::body_item_t item_in,
    output lpbp_pkg::queue_head_t head,
    input  logic                pop
);
    import lpbp_pkg::*;

    body_item_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               take;

    assign body_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push       = body_valid && !body_stall;
    assign take       = pop && head.valid;
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, take})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    `LPBP_ASSERT_NEVER(a_count_range, count_reg > QCNT_W'(QDEPTH))
    `LPBP_ASSERT_IMPLIES(a_pop_nonempty, pop, count_reg != '0)
    `LPBP_ASSERT_NEXT(a_count_up, push && !take, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ sv/lpbp_back.sv @@
`include "length_prefixed_body_parser_assert.svh"

module lpbp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  mode,
    input  lpbp_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lpbp_pkg::result_t     result
);
    import lpbp_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_LEN,
        PH_DATA,
        PH_DONE
    } phase_t;

    localparam logic [1:0] FIELDS_REQUEST  = 2'd3;
    localparam logic [1:0] FIELDS_RESPONSE = 2'd2;

    phase_t      phase_reg, phase_next;
    logic [1:0]  wbc_reg, wbc_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] rem_reg, rem_next;
    logic [1:0]  field_reg, field_next;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     res;
    logic [31:0] acc_shift;
    logic [31:0] rem_dec;
    logic [1:0]  field_inc;
    logic [1:0]  nfields;
    logic        advance;
    logic        load;
    logic [2:0]  out_kinds;
    logic        last_load;
    logic        at_start;

    assign load         = head.valid && (!out_valid_reg || !result_stall);
    assign pop          = load;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign acc_shift = {acc_reg[23:0], head.item.body_byte};
    assign rem_dec   = rem_reg - 32'd1;
    assign field_inc = field_reg + 2'd1;
    assign nfields   = mode ? FIELDS_RESPONSE : FIELDS_REQUEST;

    always_comb
    begin
        phase_next = phase_reg;
        wbc_next   = wbc_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        field_next = field_reg;
        advance    = 1'b0;
        res        = '0;
        res.message_id_out = head.item.message_id;

        unique case (phase_reg)
            PH_FIRST, PH_LEN:
            begin
                if (wbc_reg == 2'd3)
                begin
                    wbc_next = 2'd0;
                    acc_next = '0;
                    if (phase_reg == PH_FIRST && mode)
                    begin
                        res.status_valid = 1'b1;
                        res.status_word  = acc_shift;
                        phase_next       = PH_LEN;
                    end
                    else
                    begin
                        res.length_valid = 1'b1;
                        res.field_length = acc_shift;
                        res.field_index  = field_reg;
                        if (acc_shift == '0)
                        begin
                            // An empty field ends on its own length word.
                            res.field_end = 1'b1;
                            advance       = 1'b1;
                        end
                        else
                        begin
                            rem_next   = acc_shift;
                            phase_next = PH_DATA;
                        end
                    end
                end
                else
                begin
                    wbc_next = wbc_reg + 2'd1;
                    acc_next = acc_shift;
                end
            end
            PH_DATA:
            begin
                res.data_valid  = 1'b1;
                res.data_byte   = head.item.body_byte;
                res.field_index = field_reg;
                rem_next        = rem_dec;
                if (rem_dec == '0)
                begin
                    res.field_end = 1'b1;
                    advance       = 1'b1;
                end
            end
            PH_DONE:
            begin
                // Trailing words yield result words with no field data until the last one.
            end
            default:
            begin
            end
        endcase

        if (advance)
        begin
            field_next = field_inc;
            phase_next = (field_inc >= nfields) ? PH_DONE : PH_LEN;
        end

        if (head.item.body_last)
        begin
            priority if (phase_reg == PH_DONE)
                res.body_result = RES_TRAILING;
            else if (phase_next == PH_DONE)
                res.body_result = RES_ACCEPTED;
            else if (phase_next == PH_DATA)
                res.body_result = RES_TRUNC_STRING;
            else
                res.body_result = RES_TRUNC_INT;
            phase_next = PH_FIRST;
            wbc_next   = '0;
            acc_next   = '0;
            rem_next   = '0;
            field_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            wbc_reg       <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            field_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                phase_reg     <= phase_next;
                wbc_reg       <= wbc_next;
                acc_reg       <= acc_next;
                rem_reg       <= rem_next;
                field_reg     <= field_next;
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_kinds = {out_reg.data_valid, out_reg.length_valid, out_reg.status_valid};
    assign last_load = load && head.item.body_last;
    assign at_start  = (phase_reg == PH_FIRST) && (wbc_reg == 2'd0) && (field_reg == 2'd0);

    `LPBP_ASSERT_IMPLIES(a_one_kind, out_valid_reg, $onehot0(out_kinds))
    `LPBP_ASSERT_NEXT(a_clear_on_last, last_load, at_start)
    `LPBP_ASSERT_IMPLIES(a_status_mode, load && res.status_valid, mode)

endmodule

@@ sv/length_prefixed_body_parser.sv @@
// Channel   Valid          Stall          Payload
// body      body_valid     body_stall     body_byte, body_last, message_id
// result    result_valid   result_stall   field_index .. message_id_out
// config    cfg_we         (none)         cfg_wdata (format_mode)
//
// One body word is taken per cycle unless body_stall is high, and each yields
// exactly one result word. The word is written into the two-entry intake
// queue, then parsed into the output register, which a stalled result can
// delay. Reset (rst_n low, asynchronous) empties the queue, clears the parser
// and sets format_mode to request. A stalled result holds its register; the
// queue keeps taking body words until it holds two.
module length_prefixed_body_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               body_valid,
    output logic               body_stall,
    input  logic [7:0]         body_byte,
    input  logic               body_last,
    input  logic [63:0]        message_id,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         field_index,
    output logic               data_valid,
    output logic [7:0]         data_byte,
    output logic               field_end,
    output logic               length_valid,
    output logic [31:0]        field_length,
    output logic               status_valid,
    output logic signed [31:0] status_word,
    output logic [2:0]         body_result,
    output logic [63:0]        message_id_out
);
    import lpbp_pkg::*;

    logic        format_mode_reg;
    body_item_t  item_in;
    queue_head_t head;
    logic        pop;
    result_t     result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            format_mode_reg <= cfg_wdata;
        end
    end

    assign item_in.body_byte  = body_byte;
    assign item_in.body_last  = body_last;
    assign item_in.message_id = message_id;

    lpbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .body_valid (body_valid),
        .body_stall (body_stall),
        .item_in    (item_in),
        .head       (head),
        .pop        (pop)
    );

    lpbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (format_mode_reg),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign field_index    = result.field_index;
    assign data_valid     = result.data_valid;
    assign data_byte      = result.data_byte;
    assign field_end      = result.field_end;
    assign length_valid   = result.length_valid;
    assign field_length   = result.field_length;
    assign status_valid   = result.status_valid;
    assign status_word    = result.status_word;
    assign body_result    = result.body_result;
    assign message_id_out = result.message_id_out;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import lpbp_pkg::*;

    localparam int RANDOM_WORDS = 1500;
    localparam int CYCLE_LIMIT  = 500000;
    localparam bit MODE_REQUEST  = 1'b0;
    localparam bit MODE_RESPONSE = 1'b1;

    typedef enum logic [1:0]
    {
        PH_FIRST_WORD,
        PH_LENGTH,
        PH_CONTENT,
        PH_COMPLETE
    } parse_phase_t;

    typedef struct
    {
        logic [7:0]  value;
        logic        last;
        logic [63:0] id;
    } body_word_t;

    typedef struct
    {
        bit         is_cfg;
        bit         mode;
        body_word_t word;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               body_valid = 1'b0;
    logic               body_stall;
    logic [7:0]         body_byte = '0;
    logic               body_last = 1'b0;
    logic [63:0]        message_id = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [1:0]         field_index;
    logic               data_valid;
    logic [7:0]         data_byte;
    logic               field_end;
    logic               length_valid;
    logic [31:0]        field_length;
    logic               status_valid;
    logic signed [31:0] status_word;
    logic [2:0]         body_result;
    logic [63:0]        message_id_out;

    // Parser state as the testbench sees it.
    bit           model_mode = MODE_REQUEST;
    parse_phase_t model_phase = PH_FIRST_WORD;
    logic [1:0]   model_count = '0;
    logic [31:0]  model_acc = '0;
    logic [31:0]  model_remaining = '0;
    logic [1:0]   model_field = '0;

    result_t     awaited_results[$];
    body_word_t  body_queue[$];
    stim_row_t   directed_rows[$];
    int          mismatches = 0;
    int unsigned cycles = 0;
    bit          sender_quiet = 1'b0;
    bit          receiver_quiet = 1'b0;

    length_prefixed_body_parser uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function void close_field();
        model_field = model_field + 2'd1;
        model_phase = (model_field >= ((model_mode == MODE_RESPONSE) ? 2 : 3)) ?
                      PH_COMPLETE : PH_LENGTH;
    endfunction

    function result_t parse_body_byte(body_word_t w);
        result_t r;
        bit      was_complete;
        r = '0;
        r.message_id_out = w.id;
        was_complete = (model_phase == PH_COMPLETE);
        case (model_phase)
            PH_FIRST_WORD, PH_LENGTH:
            begin
                model_acc = {model_acc[23:0], w.value};
                if (model_count == 2'd3)
                begin
                    model_count = '0;
                    if (model_phase == PH_FIRST_WORD && model_mode == MODE_RESPONSE)
                    begin
                        r.status_valid = 1'b1;
                        r.status_word = model_acc;
                        model_phase = PH_LENGTH;
                    end
                    else
                    begin
                        r.length_valid = 1'b1;
                        r.field_length = model_acc;
                        r.field_index = model_field;
                        if (model_acc == 0)
                        begin
                            r.field_end = 1'b1;
                            close_field();
                        end
                        else
                        begin
                            model_remaining = model_acc;
                            model_phase = PH_CONTENT;
                        end
                    end
                    model_acc = '0;
                end
                else
                begin
                    model_count = model_count + 2'd1;
                end
            end
            PH_CONTENT:
            begin
                r.data_valid = 1'b1;
                r.data_byte = w.value;
                r.field_index = model_field;
                model_remaining = model_remaining - 1;
                if (model_remaining == 0)
                begin
                    r.field_end = 1'b1;
                    close_field();
                end
            end
            default:
            begin
            end
        endcase
        if (w.last)
        begin
            if (was_complete)
                r.body_result = RES_TRAILING;
            else if (model_phase == PH_COMPLETE)
                r.body_result = RES_ACCEPTED;
            else if (model_phase == PH_CONTENT)
                r.body_result = RES_TRUNC_STRING;
            else
                r.body_result = RES_TRUNC_INT;
            model_phase = PH_FIRST_WORD;
            model_count = '0;
            model_acc = '0;
            model_remaining = '0;
            model_field = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no result word, got one with body_result %0d",
                         $time, body_result);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("field_index", want.field_index, field_index);
                check_field("data_valid", want.data_valid, data_valid);
                check_field("data_byte", want.data_byte, data_byte);
                check_field("field_end", want.field_end, field_end);
                check_field("length_valid", want.length_valid, length_valid);
                check_field("field_length", want.field_length, field_length);
                check_field("status_valid", want.status_valid, status_valid);
                check_field("status_word", want.status_word, status_word);
                check_field("body_result", want.body_result, body_result);
                check_field("message_id_out", want.message_id_out, message_id_out);
            end
        end
    end

    // Unless quiet, the receiver may stall before taking each result word.
    initial
    begin : result_backpressure
        int hold;
        forever
        begin
            hold = receiver_quiet ? 0 : $urandom_range(0, 16);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
        end
    end

    task automatic send_body_word(input body_word_t w, input bit typed,
                                  input result_t typed_want);
        int      gap;
        result_t predicted;
        gap = sender_quiet ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            body_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        body_valid <= 1'b1;
        body_byte <= w.value;
        body_last <= w.last;
        message_id <= w.id;
        do
            @(posedge clk);
        while (body_stall);
        predicted = parse_body_byte(w);
        awaited_results.insert(awaited_results.size(), typed ? typed_want : predicted);
    endtask

    // The mode is only changed with nothing in flight, though possibly mid-body.
    task automatic apply_format_mode(input bit mode);
        body_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_mode = mode;
    endtask

    function automatic stim_row_t word_row(logic [7:0] v, logic last, logic [63:0] id);
        stim_row_t row;
        row = '{default: '0};
        row.word = '{v, last, id};
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic [7:0] v, logic last, logic [63:0] id,
                                            logic [1:0] fidx, logic dv, logic fe,
                                            logic lv, logic [31:0] flen, logic sv,
                                            logic [31:0] sword, logic [2:0] res);
        stim_row_t row;
        row = word_row(v, last, id);
        row.typed = 1'b1;
        row.want = '{fidx, dv, dv ? v : 8'h00, fe, lv, flen, sv, sword, res, id};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(bit mode);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.mode = mode;
        return row;
    endfunction

    function automatic void append_row(stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void queue_byte(logic [7:0] v, logic [63:0] id);
        body_queue.insert(body_queue.size(), '{v, 1'b0, id});
    endfunction

    function automatic void queue_word32(logic [31:0] w, logic [63:0] id);
        queue_byte(w[31:24], id);
        queue_byte(w[23:16], id);
        queue_byte(w[15:8], id);
        queue_byte(w[7:0], id);
    endfunction

    // Mostly well-formed bodies for the current mode, with cut-short, overlong
    // and noise bodies mixed in.
    function automatic void build_body();
        int          kind;
        int          nfields;
        int          len;
        int          big_field;
        int          cut;
        logic [31:0] w;
        logic [63:0] id;
        id = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(0, 255)), id);
        end
        else
        begin
            if (model_mode == MODE_RESPONSE)
            begin
                case ($urandom_range(0, 7))
                    0: w = 32'h8000_0000;
                    1: w = 32'h7FFF_FFFF;
                    2: w = 32'hFFFF_FFFF;
                    3: w = 32'h0000_0000;
                    default: w = $urandom;
                endcase
                queue_word32(w, id);
            end
            nfields = (model_mode == MODE_RESPONSE) ? 2 : 3;
            big_field = ($urandom_range(0, 5) == 0) ? $urandom_range(0, nfields - 1) : -1;
            for (int f = 0; f < nfields; f++)
            begin
                // A huge declared length always ends the body inside the content.
                if (f == big_field)
                begin
                    queue_word32($urandom | 32'h8000_0000, id);
                    repeat ($urandom_range(0, 6)) queue_byte(8'($urandom_range(0, 255)), id);
                    break;
                end
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) :
                      $urandom_range(0, 4);
                queue_word32(len, id);
                repeat (len) queue_byte(8'($urandom_range(0, 255)), id);
            end
            if (big_field < 0)
            begin
                case ($urandom_range(0, 5))
                    3:
                    begin
                        cut = $urandom_range(1, body_queue.size() - 1);
                        while (body_queue.size() > cut)
                            void'(body_queue.pop_back());
                    end
                    4: repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)), id);
                    default:
                    begin
                    end
                endcase
            end
        end
        body_queue[body_queue.size() - 1].last = 1'b1;
    endfunction

    initial
    begin : stimulus
        int          seg_left;
        logic [63:0] ones;
        ones = '1;

        // Requests: lone byte; empty field, one-byte field, maximal length cut short.
        append_row(typed_row(8'hA5, 1, ones, 0, 0, 0, 0, 0, 0, 0, RES_TRUNC_INT));
        repeat (3) append_row(word_row(8'h00, 0, 64'h0));
        append_row(typed_row(8'h00, 0, 64'h0, 0, 0, 1, 1, 0, 0, 0, RES_IN_PROGRESS));
        repeat (3) append_row(word_row(8'h00, 0, 64'h0123_4567_89AB_CDEF));
        append_row(typed_row(8'h01, 0, 64'h0, 1, 0, 0, 1, 1, 0, 0, RES_IN_PROGRESS));
        append_row(typed_row(8'hFF, 0, ones, 1, 1, 1, 0, 0, 0, 0, RES_IN_PROGRESS));
        repeat (3) append_row(word_row(8'hFF, 0, 64'h0));
        append_row(typed_row(8'hFF, 0, 64'h0, 2, 0, 0, 1, 32'hFFFF_FFFF, 0, 0,
                             RES_IN_PROGRESS));
        append_row(typed_row(8'h3C, 1, ones, 2, 1, 0, 0, 0, 0, 0, RES_TRUNC_STRING));
        // Response body: most negative status, two empty fields, then extra bytes.
        append_row(cfg_row(MODE_RESPONSE));
        append_row(word_row(8'h80, 0, 64'h0));
        repeat (2) append_row(word_row(8'h00, 0, 64'h0));
        append_row(typed_row(8'h00, 0, 64'h0, 0, 0, 0, 0, 0, 1, 32'h8000_0000,
                             RES_IN_PROGRESS));
        repeat (3) append_row(word_row(8'h00, 0, 64'h0));
        append_row(typed_row(8'h00, 0, 64'h0, 0, 0, 1, 1, 0, 0, 0, RES_IN_PROGRESS));
        repeat (3) append_row(word_row(8'h00, 0, 64'h0));
        append_row(typed_row(8'h00, 0, 64'h0, 1, 0, 1, 1, 0, 0, 0, RES_IN_PROGRESS));
        append_row(word_row(8'h5A, 0, ones));
        append_row(typed_row(8'h5A, 1, 64'h0, 0, 0, 0, 0, 0, 0, 0, RES_TRAILING));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                apply_format_mode(directed_rows[i].mode);
            else
                send_body_word(directed_rows[i].word, directed_rows[i].typed,
                               directed_rows[i].want);
        end

        seg_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (seg_left == 0)
            begin
                apply_format_mode(($urandom_range(0, 3) != 0) ? !model_mode : model_mode);
                sender_quiet = ($urandom_range(0, 3) == 0);
                receiver_quiet = ($urandom_range(0, 3) == 0);
                seg_left = $urandom_range(20, 120);
            end
            if (body_queue.size() == 0)
                build_body();
            send_body_word(body_queue.pop_front(), 1'b0, '0);
            seg_left--;
        end

        body_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
